FILE: rtl/core/lprd_pkg.sv
// Shared types and constants for the length-prefixed record deframer.
// Holds the result record layout, result kind codes and queue sizing.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lprd_pkg;

    // Result kind codes
    localparam logic [1:0] KIND_DATA         = 2'd0;
    localparam logic [1:0] KIND_EMPTY_RECORD = 2'd1;
    localparam logic [1:0] KIND_EMPTY_FRAME  = 2'd2;
    localparam logic [1:0] KIND_OVERFLOW     = 2'd3;

    // Queue between parser and output stage
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One result item
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] record_index;
        logic [7:0] char_position;
        logic [7:0] char_value;
        logic       record_done;
        logic       frame_done;
    } lprd_res_t;

endpackage

`default_nettype wire

FILE: rtl/core/lprd_front.sv
// Front end: accepts stream bytes, tracks prefixes and record/char position,
// and classifies each byte into at most one result pushed to the queue.
// Depends on lprd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lprd_front #(
    parameter int COUNT_BYTES = 1,
    parameter int LEN_BYTES   = 1,
    parameter int MAX_CHARS   = 10
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             take,       // byte accepted this cycle
    input  wire logic [7:0]       stream_byte,
    output logic                  push,
    output lprd_pkg::lprd_res_t   push_res
);
    import lprd_pkg::*;

    localparam logic [2:0] CNT_LAST = 3'(COUNT_BYTES);
    localparam logic [2:0] LEN_LAST = 3'(LEN_BYTES);
    localparam logic [7:0] MAX_C    = 8'(MAX_CHARS);

    typedef enum logic [1:0] {
        PH_COUNT = 2'd0,
        PH_LEN   = 2'd1,
        PH_DATA  = 2'd2
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [1:0] pfx_cnt_reg, pfx_cnt_next;
    logic [7:0] acc_reg, acc_next;
    logic       sat_reg, sat_next;
    logic [7:0] rec_total_reg, rec_total_next;
    logic [7:0] cur_rec_reg, cur_rec_next;
    logic [7:0] chars_total_reg, chars_total_next;
    logic [7:0] cur_char_reg, cur_char_next;

    logic [7:0] acc_upd;
    logic       sat_upd;
    logic [7:0] pfx_val;
    logic [2:0] pfx_pos1;
    logic       cnt_done;
    logic       len_done;
    logic       rec_last;
    logic       chr_last;

    // Prefix gathering: low byte kept, any nonzero higher byte saturates
    always_comb
    begin
        acc_upd  = (pfx_cnt_reg == 2'd0) ? stream_byte : acc_reg;
        sat_upd  = sat_reg | ((pfx_cnt_reg != 2'd0) && (stream_byte != 8'd0));
        pfx_val  = sat_upd ? 8'hFF : acc_upd;
        pfx_pos1 = {1'b0, pfx_cnt_reg} + 3'd1;
        cnt_done = (pfx_pos1 >= CNT_LAST);
        len_done = (pfx_pos1 >= LEN_LAST);
        rec_last = (({1'b0, cur_rec_reg} + 9'd1) >= {1'b0, rec_total_reg});
        chr_last = (({1'b0, cur_char_reg} + 9'd1) >= {1'b0, chars_total_reg});
    end

    // Next state and result classification
    always_comb
    begin
        phase_next       = phase_reg;
        pfx_cnt_next     = pfx_cnt_reg;
        acc_next         = acc_reg;
        sat_next         = sat_reg;
        rec_total_next   = rec_total_reg;
        cur_rec_next     = cur_rec_reg;
        chars_total_next = chars_total_reg;
        cur_char_next    = cur_char_reg;
        push             = 1'b0;
        push_res         = '0;

        if (take)
        begin
            unique case (phase_reg)
                PH_LEN:
                begin
                    if (len_done)
                    begin
                        pfx_cnt_next     = 2'd0;
                        acc_next         = 8'd0;
                        sat_next         = 1'b0;
                        chars_total_next = pfx_val;
                        cur_char_next    = 8'd0;
                        if (pfx_val != 8'd0)
                        begin
                            phase_next = PH_DATA;
                        end
                        else
                        begin
                            push                   = 1'b1;
                            push_res.kind          = KIND_EMPTY_RECORD;
                            push_res.record_index  = cur_rec_reg;
                            push_res.record_done   = 1'b1;
                            push_res.frame_done    = rec_last;
                            cur_rec_next           = cur_rec_reg + 8'd1;
                            phase_next             = rec_last ? PH_COUNT : PH_LEN;
                        end
                    end
                    else
                    begin
                        pfx_cnt_next = pfx_cnt_reg + 2'd1;
                        acc_next     = acc_upd;
                        sat_next     = sat_upd;
                    end
                end
                PH_DATA:
                begin
                    push                   = 1'b1;
                    push_res.kind          = (cur_char_reg < MAX_C) ? KIND_DATA
                                                                    : KIND_OVERFLOW;
                    push_res.record_index  = cur_rec_reg;
                    push_res.char_position = cur_char_reg;
                    push_res.char_value    = stream_byte;
                    push_res.record_done   = chr_last;
                    push_res.frame_done    = chr_last && rec_last;
                    if (chr_last)
                    begin
                        cur_char_next = 8'd0;
                        cur_rec_next  = cur_rec_reg + 8'd1;
                        phase_next    = rec_last ? PH_COUNT : PH_LEN;
                    end
                    else
                    begin
                        cur_char_next = cur_char_reg + 8'd1;
                    end
                end
                default:
                begin
                    // record count, also taken for the unused phase code
                    phase_next = PH_COUNT;
                    if (cnt_done)
                    begin
                        pfx_cnt_next   = 2'd0;
                        acc_next       = 8'd0;
                        sat_next       = 1'b0;
                        rec_total_next = pfx_val;
                        cur_rec_next   = 8'd0;
                        cur_char_next  = 8'd0;
                        if (pfx_val != 8'd0)
                        begin
                            phase_next = PH_LEN;
                        end
                        else
                        begin
                            push                = 1'b1;
                            push_res.kind       = KIND_EMPTY_FRAME;
                            push_res.frame_done = 1'b1;
                        end
                    end
                    else
                    begin
                        pfx_cnt_next = pfx_cnt_reg + 2'd1;
                        acc_next     = acc_upd;
                        sat_next     = sat_upd;
                    end
                end
            endcase
        end
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_COUNT;
            pfx_cnt_reg     <= 2'd0;
            acc_reg         <= 8'd0;
            sat_reg         <= 1'b0;
            rec_total_reg   <= 8'd0;
            cur_rec_reg     <= 8'd0;
            chars_total_reg <= 8'd0;
            cur_char_reg    <= 8'd0;
        end
        else
        begin
            phase_reg       <= phase_next;
            pfx_cnt_reg     <= pfx_cnt_next;
            acc_reg         <= acc_next;
            sat_reg         <= sat_next;
            rec_total_reg   <= rec_total_next;
            cur_rec_reg     <= cur_rec_next;
            chars_total_reg <= chars_total_next;
            cur_char_reg    <= cur_char_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/lprd_queue.sv
// Short result queue between the parser and the output stage.
// Register-based, one push and one pop per cycle. Depends on lprd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lprd_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire lprd_pkg::lprd_res_t  push_res,
    input  wire logic                 pop,
    output lprd_pkg::lprd_res_t       pop_res,
    output logic                      full,
    output logic                      empty
);
    import lprd_pkg::*;

    lprd_res_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_res = mem_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_res;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/lprd_back.sv
// Back end: output register that drains the result queue onto the
// master-side stream. Depends on lprd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lprd_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 empty,
    input  wire lprd_pkg::lprd_res_t  pop_res,
    output logic                      pop,
    output logic                      out_valid,
    output lprd_pkg::lprd_res_t       out_res,
    input  wire logic                 out_ready
);
    import lprd_pkg::*;

    logic      valid_reg, valid_next;
    lprd_res_t res_reg;

    // Refill whenever the register is free or being taken this cycle
    assign pop        = !empty && (!valid_reg || out_ready);
    assign valid_next = pop || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign out_res    = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= pop_res;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/length_prefix_record_deframer_core.sv
// Length-prefixed record deframer, top level.
// Throughput: one byte per cycle; input stalls only when the 4-entry result queue is full.
// Path: the parser pushes a result into the queue when its byte is taken, and the output register
// then loads it from the queue and drives m_tvalid; while that register is held, results wait in the queue.
// Reset (rst_n low, asynchronous): parser expects a record count, queue and output empty.
`timescale 1ns / 1ps
`default_nettype none

module length_prefix_record_deframer_core #(
    parameter int COUNT_BYTES = 1,
    parameter int LEN_BYTES   = 1,
    parameter int MAX_CHARS   = 10
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] stream_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] record_index, [15:8] char_position,
                                        // [23:16] char_value
    output logic [2:0]       m_tuser,   // [1:0] kind, [2] record_done
    output logic             m_tlast    // frame_done
);
    import lprd_pkg::*;

    logic      take;
    logic      push;
    lprd_res_t push_res;
    logic      pop;
    lprd_res_t pop_res;
    logic      full;
    logic      empty;
    lprd_res_t out_res;

    assign s_tready = !full;
    assign take     = s_tvalid && s_tready;

    lprd_front #(
        .COUNT_BYTES (COUNT_BYTES),
        .LEN_BYTES   (LEN_BYTES),
        .MAX_CHARS   (MAX_CHARS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .stream_byte (s_tdata),
        .push        (push),
        .push_res    (push_res)
    );

    lprd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_res (push_res),
        .pop      (pop),
        .pop_res  (pop_res),
        .full     (full),
        .empty    (empty)
    );

    lprd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .pop_res   (pop_res),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_res   (out_res),
        .out_ready (m_tready)
    );

    // Output beat packing
    assign m_tdata = {out_res.char_value, out_res.char_position, out_res.record_index};
    assign m_tuser = {out_res.record_done, out_res.kind};
    assign m_tlast = out_res.frame_done;

    // Parser never pushes into a full queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("result pushed into full queue");

    // Queue cannot be full and empty at once
    a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(full && empty))
        else $error("queue full and empty together");

    // Empty-frame marker always closes the frame and no record
    a_empty_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser[1:0] == KIND_EMPTY_FRAME)) |-> (m_tlast && !m_tuser[2]))
        else $error("empty-frame beat with bad flags");

    // Overflow beats only at positions past the character limit
    a_overflow_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser[1:0] == KIND_OVERFLOW)) |-> (m_tdata[15:8] >= 8'(MAX_CHARS)))
        else $error("overflow beat below character limit");

    // A frame end always ends a record, except for the empty-frame marker
    a_frame_ends_record: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast && (m_tuser[1:0] != KIND_EMPTY_FRAME)) |-> m_tuser[2])
        else $error("frame end without record end");

endmodule

`default_nettype wire
